@@ src/sliding_window_median_macros.svh @@
// Assertion macros for the checker file of the median filter.
`ifndef SLIDING_WINDOW_MEDIAN_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define SWM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent in the cycle after the antecedent.
`define SWM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/swm_pkg.sv @@
// Shared types and constants for the sliding-window median filter.
package swm_pkg;

  localparam int MAX_WINDOW_DEF = 64;
  localparam int SAMPLE_W       = 32;
  localparam int MEDIAN_W       = 33;
  localparam int CFG_W          = 7;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [MEDIAN_W-1:0] median_t;

  // Command broadcast to every cell of the sorted chain.
  typedef struct packed {
    logic    clr;
    logic    rem;
    logic    ins;
    sample_t key;
  } cell_cmd_t;

endpackage

@@ src/sliding_window_median.sv @@
// Top level of the sliding-window median filter.
//
//  channel   direction  handshake            payload
//  in_       input      in_valid / in_stall   in_sample (32b signed)
//  out_      output     out_valid / out_stall out_median_doubled (33b signed)
//  cfg_      input      cfg_write_en          cfg_window_length (7b)
//
// A transfer that leaves the window short is accepted, then inserted; the one that
// fills it is accepted, inserted, then its middles are picked and summed; each later
// one is accepted, removes the oldest, inserts, then picks the middles and sums them.
// The oldest sample is read from the arrival ring on accept and removed in the next cycle.
// The sum step waits while the output register holds an untaken result.
// Reset and every window_length write empty the window; no clearing pass is run.
module sliding_window_median #(
  parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  swm_pkg::sample_t            in_sample,
  output logic                        out_valid,
  input  logic                        out_stall,
  output swm_pkg::median_t            out_median_doubled,
  input  logic                        cfg_write_en,
  input  logic [swm_pkg::CFG_W-1:0]   cfg_window_length
);

  localparam int LW  = $clog2(MAX_WINDOW + 1);
  localparam int PW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int XW  = (LW > swm_pkg::CFG_W) ? LW : swm_pkg::CFG_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_REM  = 3'd1;
  localparam logic [2:0] ST_INS  = 3'd2;
  localparam logic [2:0] ST_PICK = 3'd3;
  localparam logic [2:0] ST_SUM  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [LW-1:0]    len_r;
  logic [LW-1:0]    fill_r;
  logic [PW-1:0]    oldest_r;
  logic [PW-1:0]    lo_idx_r, hi_idx_r;
  logic             emit_r;
  swm_pkg::sample_t samp_r;
  swm_pkg::sample_t ring_rd_r;
  swm_pkg::sample_t pick_lo_r, pick_hi_r;
  logic             out_valid_r;
  swm_pkg::median_t out_median_r;

  logic [31:0]      ring [MAX_WINDOW];

  logic             accept;
  logic             full;
  logic [PW-1:0]    wr_addr;
  logic [XW-1:0]    cfg_ext;
  logic [LW-1:0]    len_cfg;
  logic [LW-1:0]    half_cfg;
  logic [LW-1:0]    fill_inc;
  logic [LW-1:0]    oldest_inc;
  logic             out_load;

  swm_pkg::cell_cmd_t cmd;
  swm_pkg::sample_t   vals [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] occs;
  logic [MAX_WINDOW-1:0] gts;

  assign accept     = in_valid && !in_stall;
  assign in_stall   = (state_r != ST_IDLE);
  assign full       = (fill_r == len_r);
  assign wr_addr    = full ? oldest_r : fill_r[PW-1:0];
  assign fill_inc   = fill_r + LW'(1);
  assign oldest_inc = LW'(oldest_r) + LW'(1);
  assign out_load   = (state_r == ST_SUM) && (!out_valid_r || !out_stall);

  // effective length: zero acts as one, oversize clamps to the chain depth
  assign cfg_ext  = XW'(cfg_window_length);
  assign len_cfg  = (cfg_ext == '0) ? LW'(1) :
                    (cfg_ext > XW'(MAX_WINDOW)) ? LW'(MAX_WINDOW) : LW'(cfg_ext);
  assign half_cfg = len_cfg >> 1;

  always_comb begin
    cmd.clr = cfg_write_en;
    cmd.rem = (state_r == ST_REM);
    cmd.ins = (state_r == ST_INS);
    cmd.key = (state_r == ST_REM) ? ring_rd_r : samp_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = full ? ST_REM : ST_INS;
        end
      end
      ST_REM:  state_nxt = ST_INS;
      ST_INS:  state_nxt = emit_r ? ST_PICK : ST_IDLE;
      ST_PICK: state_nxt = ST_SUM;
      ST_SUM: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= LW'(1);
      lo_idx_r    <= '0;
      hi_idx_r    <= '0;
      fill_r      <= '0;
      oldest_r    <= '0;
      emit_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_write_en) begin
        len_r    <= len_cfg;
        hi_idx_r <= PW'(half_cfg);
        lo_idx_r <= len_cfg[0] ? PW'(half_cfg) : PW'(half_cfg - LW'(1));
        fill_r   <= '0;
        oldest_r <= '0;
      end else if (accept) begin
        if (full) begin
          oldest_r <= (oldest_inc == len_r) ? '0 : PW'(oldest_inc);
          emit_r   <= 1'b1;
        end else begin
          fill_r <= fill_inc;
          emit_r <= (fill_inc == len_r);
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ring[wr_addr] <= in_sample;
      ring_rd_r     <= ring[oldest_r];
      samp_r        <= in_sample;
    end
    if (state_r == ST_PICK) begin
      pick_lo_r <= vals[lo_idx_r];
      pick_hi_r <= vals[hi_idx_r];
    end
    if (out_load) begin
      out_median_r <= swm_pkg::median_t'(pick_lo_r) + swm_pkg::median_t'(pick_hi_r);
    end
  end

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    swm_pkg::sample_t lv, rv;
    logic             lg, lo, ro;
    if (i == 0) begin : g_first
      assign lv = '0;
      assign lg = 1'b0;
      assign lo = 1'b1;
    end else begin : g_mid
      assign lv = vals[i-1];
      assign lg = gts[i-1];
      assign lo = occs[i-1];
    end
    if (i == MAX_WINDOW - 1) begin : g_last
      assign rv = '0;
      assign ro = 1'b0;
    end else begin : g_body
      assign rv = vals[i+1];
      assign ro = occs[i+1];
    end
    swm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .left_val  (lv),
      .left_gt   (lg),
      .left_occ  (lo),
      .right_val (rv),
      .right_occ (ro),
      .val       (vals[i]),
      .occ       (occs[i]),
      .gt        (gts[i])
    );
  end

  assign out_valid          = out_valid_r;
  assign out_median_doubled = out_median_r;

endmodule

@@ src/swm_cell.sv @@
// One slot of the sorted chain: clears on command, or removes or inserts by trading with its neighbors.
module swm_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  swm_pkg::cell_cmd_t cmd,
  input  swm_pkg::sample_t   left_val,
  input  logic               left_gt,
  input  logic               left_occ,
  input  swm_pkg::sample_t   right_val,
  input  logic               right_occ,
  output swm_pkg::sample_t   val,
  output logic               occ,
  output logic               gt
);

  swm_pkg::sample_t val_r;
  swm_pkg::sample_t val_nxt;
  logic             occ_r;
  logic             occ_nxt;
  logic             ge_key;

  assign ge_key = occ_r && (val_r >= cmd.key);
  assign gt     = !occ_r || (val_r > cmd.key);
  assign val    = val_r;
  assign occ    = occ_r;

  always_comb begin
    val_nxt = val_r;
    occ_nxt = occ_r;
    if (cmd.clr) begin
      occ_nxt = 1'b0;
    end else if (cmd.rem) begin
      // first slot holding the key and every slot above it pull from the right
      if (ge_key) begin
        val_nxt = right_val;
      end
      occ_nxt = right_occ;
    end else if (cmd.ins) begin
      if (left_gt) begin
        val_nxt = left_val;
      end else if (gt) begin
        val_nxt = cmd.key;
      end
      occ_nxt = occ_r || left_occ;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

@@ src/sliding_window_median_chk.sv @@
// Port-level checker for the sliding-window median filter, bound to the top level.
`include "sliding_window_median_macros.svh"

module sliding_window_median_chk (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input swm_pkg::median_t          out_median_doubled,
  input logic                      cfg_write_en
);

  `SWM_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_median_doubled), "stalled result changed or dropped")
  `SWM_ASSERT_NEXT(a_busy_after_transfer, in_valid && !in_stall, in_stall,
    "input not stalled while an item is in work")
  `SWM_ASSERT_NOW(a_result_from_work, $rose(out_valid), $past(in_stall),
    "result appeared without item in work")
  `SWM_ASSERT_NEXT(a_cfg_keeps_idle, cfg_write_en && !in_stall && !in_valid, !in_stall,
    "config write started work")

endmodule

bind sliding_window_median sliding_window_median_chk u_chk (.*);

@@ verif/tb_sliding_window_median.sv @@
// Testbench for the sliding-window median filter: directed table, then randomized phases.
module tb_sliding_window_median;

  localparam int MAX_SPAN     = swm_pkg::MAX_WINDOW_DEF;
  localparam int DIR_ROWS     = 23;
  localparam int RANDOM_ITEMS = 1350;
  localparam int SETTLE       = 16;
  localparam int NUM_LENS     = 12;

  typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [31:0]        value;
    bit                 typed;
    swm_pkg::median_t   want;
  } dir_row_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  swm_pkg::sample_t            in_sample = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  swm_pkg::median_t            out_median_doubled;
  logic                        cfg_write_en = 1'b0;
  logic [swm_pkg::CFG_W-1:0]   cfg_window_length = '0;

  int                          send_idle_pct = 0;
  int                          stall_pct = 0;
  int                          fail_count = 0;
  swm_pkg::median_t            pending_medians[$];
  swm_pkg::median_t            mon_want;

  // filter state mirror
  logic [swm_pkg::CFG_W-1:0]   win_len_raw = 7'd1;
  swm_pkg::sample_t            arrival_buf [MAX_SPAN];
  swm_pkg::sample_t            ordered_buf [MAX_SPAN];
  int                          held_count = 0;
  int                          oldest_slot = 0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_SAMPLE, 32'd5,          1'b1, 33'd10},
    '{ROW_SAMPLE, 32'h7FFF_FFFF,  1'b1, 33'h0_FFFF_FFFE},
    '{ROW_SAMPLE, 32'h8000_0000,  1'b1, 33'h1_0000_0000},
    '{ROW_SAMPLE, 32'h0000_0000,  1'b1, 33'h0_0000_0000},
    '{ROW_SAMPLE, 32'hFFFF_FFFF,  1'b1, 33'h1_FFFF_FFFE},
    '{ROW_CFG,    32'd0,          1'b0, 33'd0},
    '{ROW_SAMPLE, 32'd7,          1'b1, 33'd14},
    '{ROW_CFG,    32'd2,          1'b0, 33'd0},
    '{ROW_SAMPLE, 32'h7FFF_FFFF,  1'b0, 33'd0},
    '{ROW_SAMPLE, 32'h7FFF_FFFF,  1'b1, 33'h0_FFFF_FFFE},
    '{ROW_SAMPLE, 32'h8000_0000,  1'b1, 33'h1_FFFF_FFFF},
    '{ROW_SAMPLE, 32'h8000_0000,  1'b1, 33'h1_0000_0000},
    '{ROW_CFG,    32'd3,          1'b0, 33'd0},
    '{ROW_SAMPLE, 32'd4,          1'b0, 33'd0},
    '{ROW_SAMPLE, 32'd4,          1'b0, 33'd0},
    '{ROW_SAMPLE, 32'd9,          1'b0, 33'd0},
    '{ROW_SAMPLE, 32'd1,          1'b0, 33'd0},
    '{ROW_SAMPLE, 32'd1,          1'b0, 33'd0},
    '{ROW_CFG,    32'd127,        1'b0, 33'd0},
    '{ROW_SAMPLE, 32'd3,          1'b0, 33'd0},
    '{ROW_CFG,    32'd2,          1'b0, 33'd0},
    '{ROW_SAMPLE, 32'd6,          1'b0, 33'd0},
    '{ROW_SAMPLE, 32'hFFFF_FFFA,  1'b1, 33'd0}
  };

  logic [swm_pkg::CFG_W-1:0] phase_lens [NUM_LENS] = '{
    7'd127, 7'd1, 7'd0, 7'd64, 7'd2, 7'd65, 7'd3, 7'd63, 7'd4, 7'd8, 7'd5, 7'd16
  };

  sliding_window_median u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample          (in_sample),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_median_doubled (out_median_doubled),
    .cfg_write_en       (cfg_write_en),
    .cfg_window_length  (cfg_window_length)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic int span_of(logic [swm_pkg::CFG_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > MAX_SPAN) return MAX_SPAN;
    return int'(raw);
  endfunction

  function automatic void sorted_place(int n, swm_pkg::sample_t v);
    int pos;
    pos = n;
    while (pos > 0 && ordered_buf[pos-1] > v) begin
      ordered_buf[pos] = ordered_buf[pos-1];
      pos--;
    end
    ordered_buf[pos] = v;
  endfunction

  function automatic void queue_median(swm_pkg::median_t m);
    pending_medians = {pending_medians, m};
  endfunction

  task automatic median_update(input swm_pkg::sample_t s, output bit emits,
                               output swm_pkg::median_t m);
    int     n;
    int     i;
    longint sum;
    n = span_of(win_len_raw);
    if (held_count < n) begin
      arrival_buf[held_count] = s;
      sorted_place(held_count, s);
      held_count++;
      emits = (held_count == n);
    end else begin
      i = 0;
      while (i < n && ordered_buf[i] != arrival_buf[oldest_slot]) i++;
      for (; i + 1 < n; i++) ordered_buf[i] = ordered_buf[i+1];
      sorted_place(n - 1, s);
      arrival_buf[oldest_slot] = s;
      oldest_slot = (oldest_slot + 1 == n) ? 0 : oldest_slot + 1;
      emits = 1'b1;
    end
    if (n % 2)
      sum = 2 * longint'(ordered_buf[n/2]);
    else
      sum = longint'(ordered_buf[n/2-1]) + longint'(ordered_buf[n/2]);
    m = sum[swm_pkg::MEDIAN_W-1:0];
  endtask

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic swm_pkg::sample_t pick_sample();
    swm_pkg::sample_t v;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0:       v = 32'h7FFF_FFFF;
          1:       v = 32'h8000_0000;
          2:       v = '0;
          default: v = '1;
        endcase
      end
      1, 2, 3: v = swm_pkg::sample_t'(int'($urandom_range(6)) - 3);
      4:       v = $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(3)
                                     : 32'h8000_0000 + $urandom_range(3);
      default: v = $urandom();
    endcase
    return v;
  endfunction

  task automatic send_sample(input swm_pkg::sample_t s, input bit typed,
                             input swm_pkg::median_t want);
    bit               emits;
    swm_pkg::median_t got;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (in_stall);
    median_update(s, emits, got);
    if (emits) queue_median(typed ? want : got);
  endtask

  task automatic write_length(input logic [swm_pkg::CFG_W-1:0] v);
    in_valid <= 1'b0;
    while (pending_medians.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_window_length <= v;
    cfg_write_en      <= 1'b1;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    win_len_raw = v;
    held_count  = 0;
    oldest_slot = 0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_medians.size() == 0) begin
        report_mismatch($sformatf("unexpected median %0d", out_median_doubled));
      end else begin
        mon_want = pending_medians.pop_front();
        if (out_median_doubled !== mon_want)
          report_mismatch($sformatf("median_doubled got %0d want %0d",
                                    out_median_doubled, mon_want));
      end
    end
  end

  initial begin : stimulus
    int                        k;
    int                        p;
    int                        n_items;
    int                        phase_items;
    int                        span;
    int                        mode;
    logic [swm_pkg::CFG_W-1:0] raw;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < DIR_ROWS; k++) begin
      if (dir_rows[k].kind == ROW_CFG)
        write_length(dir_rows[k].value[swm_pkg::CFG_W-1:0]);
      else
        send_sample(dir_rows[k].value, dir_rows[k].typed, dir_rows[k].want);
    end

    p = 0;
    n_items = 0;
    while (n_items < RANDOM_ITEMS) begin
      if (p < NUM_LENS)
        raw = phase_lens[p];
      else if ($urandom_range(9) == 0)
        raw = $urandom_range(127);
      else
        raw = $urandom_range(12, 1);
      write_length(raw);
      mode = p % 4;
      send_idle_pct = (mode == 1) ? 65 : (mode == 3) ? 15 : 0;
      stall_pct     = (mode == 2) ? 65 : (mode == 3) ? 15 : 0;
      span = span_of(raw);
      phase_items = span + $urandom_range(60, 20);
      // occasionally rewrite the length before the window fills
      if (span > 1 && $urandom_range(7) == 0) phase_items = $urandom_range(span - 1);
      repeat (phase_items) send_sample(pick_sample(), 1'b0, '0);
      n_items += phase_items;
      p++;
    end

    in_valid <= 1'b0;
    while (pending_medians.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
